// File: rtl/core/twm_pkg.sv
// twm_pkg: shared types, constants and helpers for the windowed median block
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package twm_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int VAL_W     = 24;
	localparam int TIME_W    = 32;
	// shared compare unit works on 33-bit signed operands (value or time)
	localparam int CMP_W     = 33;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] sample_value;
		logic [TIME_W-1:0]       sample_time;
		logic [TIME_W-1:0]       cutoff_time;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] median_value;
		logic                    has_value;
	} rsp_t;

	typedef struct packed {
		logic                    en;
		logic signed [VAL_W-1:0] value;
		logic [TIME_W-1:0]       stamp;
	} ring_wr_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SCAN_RD  = 8'b0000_0010,
		ST_SCAN_CMP = 8'b0000_0100,
		ST_G_RD     = 8'b0000_1000,
		ST_G_LD     = 8'b0001_0000,
		ST_INNER    = 8'b0010_0000,
		ST_EVAL     = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} seq_state_t;

	function automatic logic signed [CMP_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
		sext_val = {{(CMP_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	function automatic logic signed [CMP_W-1:0] zext_time(input logic [TIME_W-1:0] t);
		zext_time = {{(CMP_W-TIME_W){1'b0}}, t};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/twm_cmp.sv
// twm_cmp: shared signed greater-or-equal unit used for time and value checks
// depends on twm_pkg
`timescale 1ns / 1ps
`default_nettype none

module twm_cmp import twm_pkg::*; (
	input  wire logic signed [CMP_W-1:0] a,
	input  wire logic signed [CMP_W-1:0] b,
	output logic                         ge
);

	assign ge = (a >= b);

endmodule

`default_nettype wire

// File: rtl/core/twm_ring.sv
// twm_ring: sample ring with value and time memories, ring pointers and fill size
// depends on twm_pkg
`timescale 1ns / 1ps
`default_nettype none

module twm_ring import twm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int PW = $clog2(SLOTS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ring_wr_t                wr,
	input  wire logic [PW-1:0]           rd_pos,
	output logic [PW-1:0]                size,
	output logic signed [VAL_W-1:0]      rd_value,
	output logic [TIME_W-1:0]            rd_time
);

	logic signed [VAL_W-1:0] value_mem [SLOTS];
	logic [TIME_W-1:0]       time_mem [SLOTS];

	logic [PW-1:0] oldest_q;
	logic [PW-1:0] next_q;
	logic [PW-1:0] next_inc;
	logic [PW-1:0] oldest_inc;
	logic [PW:0]   rd_sum;
	logic [PW-1:0] rd_slot;
	logic [PW:0]   size_raw;

	assign next_inc   = (next_q == PW'(SLOTS - 1)) ? '0 : next_q + PW'(1);
	assign oldest_inc = (oldest_q == PW'(SLOTS - 1)) ? '0 : oldest_q + PW'(1);

	// position relative to the oldest entry, wrapped into the ring
	assign rd_sum  = {1'b0, oldest_q} + {1'b0, rd_pos};
	assign rd_slot = (rd_sum >= (PW+1)'(SLOTS)) ? PW'(rd_sum - (PW+1)'(SLOTS)) : rd_sum[PW-1:0];

	assign size_raw = (next_q >= oldest_q) ? ({1'b0, next_q} - {1'b0, oldest_q})
	                                       : ({1'b0, next_q} + (PW+1)'(SLOTS) - {1'b0, oldest_q});
	assign size = size_raw[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			next_q   <= '0;
		end else if (wr.en) begin
			next_q <= next_inc;
			// ring full: drop the oldest entry
			if (next_inc == oldest_q) begin
				oldest_q <= oldest_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			value_mem[next_q] <= wr.value;
			time_mem[next_q]  <= wr.stamp;
		end
		rd_value <= value_mem[rd_slot];
		rd_time  <= time_mem[rd_slot];
	end

endmodule

`default_nettype wire

// File: rtl/core/twm_seq.sv
// twm_seq: sequencer for window scan and pairwise rank count over the shared compare unit
// depends on twm_pkg; drives twm_ring read position and twm_cmp operands
`timescale 1ns / 1ps
`default_nettype none

module twm_seq import twm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int PW = $clog2(SLOTS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_acc,
	input  wire req_t                    req,
	output logic                         idle,
	input  wire logic [PW-1:0]           size,
	output logic [PW-1:0]                rd_pos,
	input  wire logic signed [VAL_W-1:0] rd_value,
	input  wire logic [TIME_W-1:0]       rd_time,
	output ring_wr_t                     wr,
	output logic signed [CMP_W-1:0]      cmp_a,
	output logic signed [CMP_W-1:0]      cmp_b,
	input  wire logic                    cmp_ge,
	output logic                         res_valid,
	input  wire logic                    res_free,
	output rsp_t                         res
);

	localparam int CW = PW + 1;
	localparam int DW = PW + 2;

	seq_state_t state_q, state_d;

	logic [TIME_W-1:0]       cutoff_q;
	logic [PW-1:0]           size_q;
	logic [PW-1:0]           first_q;
	logic [PW-1:0]           g_q;
	logic [PW-1:0]           i_q;
	logic [PW-1:0]           chk_idx_s1;
	logic                    chk_vld_s1;
	logic signed [VAL_W-1:0] gv_q;
	logic [CW-1:0]           less_q;
	logic [CW-1:0]           greater_q;
	logic [DW-1:0]           best_diff_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic                    has_q;
	logic [CW-1:0]           diff;
	logic                    is_query;

	assign is_query = req_acc && (req.kind == KIND_QUERY);
	assign idle     = (state_q == ST_IDLE);

	assign wr.en    = req_acc && (req.kind == KIND_ADD);
	assign wr.value = req.sample_value;
	assign wr.stamp = req.sample_time;

	assign diff = (less_q > greater_q) ? (less_q - greater_q) : (greater_q - less_q);

	assign res_valid        = (state_q == ST_DONE);
	assign res.median_value = best_val_q;
	assign res.has_value    = has_q;

	always_comb begin
		unique case (state_q)
			ST_SCAN_RD:  rd_pos = first_q - PW'(1);
			ST_G_RD:     rd_pos = g_q;
			default:     rd_pos = i_q;
		endcase
	end

	// scan checks time >= cutoff, inner loop checks value_i <= candidate
	always_comb begin
		if (state_q == ST_SCAN_CMP) begin
			cmp_a = zext_time(rd_time);
			cmp_b = zext_time(cutoff_q);
		end else begin
			cmp_a = sext_val(gv_q);
			cmp_b = sext_val(rd_value);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_query) begin
					state_d = (size == '0) ? ST_DONE : ST_SCAN_RD;
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (cmp_ge) begin
					state_d = (first_q == PW'(1)) ? ST_G_RD : ST_SCAN_RD;
				end else begin
					state_d = (first_q == size_q) ? ST_DONE : ST_G_RD;
				end
			end
			ST_G_RD:     state_d = ST_G_LD;
			ST_G_LD:     state_d = ST_INNER;
			ST_INNER: begin
				if (i_q == size_q && !chk_vld_s1) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL:     state_d = (g_q + PW'(1) == size_q) ? ST_DONE : ST_G_RD;
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= (state_q == ST_INNER) && (i_q != size_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (is_query) begin
					cutoff_q    <= req.cutoff_time;
					size_q      <= size;
					first_q     <= size;
					best_val_q  <= '0;
					best_diff_q <= DW'(2 * SLOTS);
					has_q       <= 1'b0;
				end
			end
			ST_SCAN_CMP: begin
				if (cmp_ge) begin
					first_q <= first_q - PW'(1);
					g_q     <= first_q - PW'(1);
				end else begin
					g_q <= first_q;
				end
			end
			ST_G_LD: begin
				gv_q      <= rd_value;
				i_q       <= first_q;
				less_q    <= '0;
				greater_q <= '0;
			end
			ST_INNER: begin
				if (i_q != size_q) begin
					chk_idx_s1 <= i_q;
					i_q        <= i_q + PW'(1);
				end
				// the candidate itself is not counted
				if (chk_vld_s1 && chk_idx_s1 != g_q) begin
					if (cmp_ge) begin
						less_q <= less_q + CW'(1);
					end else begin
						greater_q <= greater_q + CW'(1);
					end
				end
			end
			ST_EVAL: begin
				// strict less keeps the earliest candidate on ties
				if ({1'b0, diff} < best_diff_q) begin
					best_diff_q <= {1'b0, diff};
					best_val_q  <= gv_q;
				end
				has_q <= 1'b1;
				g_q   <= g_q + PW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/timestamped_window_median_top.sv
// channel | role   | handshake          | payload
// req     | input  | req_valid/req_stall | req_t: kind, sample_value, sample_time, cutoff_time
// rsp     | output | rsp_valid/rsp_stall | rsp_t: median_value, has_value
//
// an add transaction yields no response
// a query scans back from the newest entry, then counts ranks pairwise over the window entries;
// both steps share the single memory read port and the one shared compare unit
// req_stall is high from query accept until its result is placed in the response register
// arst_n clears the ring pointers and sequencer; sample memories hold no reset
// depends on twm_pkg, twm_cmp, twm_ring, twm_seq
`timescale 1ns / 1ps
`default_nettype none

module timestamped_window_median_top import twm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int PW = $clog2(SLOTS);

	logic                    req_acc;
	logic                    idle;
	logic [PW-1:0]           size;
	logic [PW-1:0]           rd_pos;
	logic signed [VAL_W-1:0] rd_value;
	logic [TIME_W-1:0]       rd_time;
	ring_wr_t                wr;
	logic signed [CMP_W-1:0] cmp_a;
	logic signed [CMP_W-1:0] cmp_b;
	logic                    cmp_ge;
	logic                    res_valid;
	logic                    res_free;
	rsp_t                    res;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	assign req_stall = !idle;
	assign req_acc   = req_valid && !req_stall;
	assign res_free  = !rsp_valid_q || !rsp_stall;

	twm_ring #(.SLOTS(SLOTS)) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_pos   (rd_pos),
		.size     (size),
		.rd_value (rd_value),
		.rd_time  (rd_time)
	);

	twm_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.ge (cmp_ge)
	);

	twm_seq #(.SLOTS(SLOTS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_acc   (req_acc),
		.req       (req),
		.idle      (idle),
		.size      (size),
		.rd_pos    (rd_pos),
		.rd_value  (rd_value),
		.rd_time   (rd_time),
		.wr        (wr),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_ge    (cmp_ge),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res)
	);

	// response register parts the sequencer from the output stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.kind == KIND_QUERY |=> req_stall)
		else $error("query transaction did not start the sequencer");

	a_add_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.kind == KIND_ADD |=> !req_stall)
		else $error("add transaction left the block busy");

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a query in flight");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_value |-> rsp.median_value == '0)
		else $error("empty window response carries a nonzero value");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// tb_top: self-checking bench for timestamped_window_median_top
// depends on twm_pkg (req_t, rsp_t, kind codes) and the top level rtl
`timescale 1ns / 1ps

module tb_top;
	import twm_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int QUERY_CYCLES = 1200;
	localparam int PHASE_ITEMS = 185;

	typedef struct {
		req_t item;
		bit   fixed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// local copy of the sample ring
	logic signed [VAL_W-1:0] ring_val [NSLOT];
	logic [TIME_W-1:0]       ring_stamp [NSLOT];
	int                      oldest_slot = 0;
	int                      next_slot = 0;
	logic [TIME_W-1:0]       stamp_now = '0;

	rsp_t expected_medians [$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   fail_count = 0;
	int   n_adds = 0;
	int   n_queries = 0;
	int   n_empty = 0;
	int   n_evictions = 0;

	timestamped_window_median_top #(.SLOTS(NSLOT)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rsp_t median_of_window(input logic [TIME_W-1:0] cutoff);
		int count, first, g, i, less, greater, diff, best_diff;
		logic signed [VAL_W-1:0] gv;
		rsp_t r;
		count = (next_slot + NSLOT - oldest_slot) % NSLOT;
		first = count;
		r = '0;
		// walk back from the newest entry, stop at the first one older than cutoff
		while (first > 0 && ring_stamp[(oldest_slot + first - 1) % NSLOT] >= cutoff)
			first--;
		if (first == count)
			return r;
		best_diff = 2 * NSLOT;
		for (g = first; g < count; g++) begin
			gv = ring_val[(oldest_slot + g) % NSLOT];
			less = 0;
			greater = 0;
			for (i = first; i < count; i++) begin
				if (i != g) begin
					if (ring_val[(oldest_slot + i) % NSLOT] <= gv)
						less++;
					else
						greater++;
				end
			end
			diff = (less > greater) ? less - greater : greater - less;
			// strict compare keeps the oldest candidate on a tie
			if (diff < best_diff) begin
				best_diff = diff;
				r.median_value = gv;
			end
		end
		r.has_value = 1'b1;
		return r;
	endfunction

	function automatic void store_sample(input req_t item);
		ring_val[next_slot] = item.sample_value;
		ring_stamp[next_slot] = item.sample_time;
		next_slot = (next_slot + 1) % NSLOT;
		if (next_slot == oldest_slot) begin
			oldest_slot = (oldest_slot + 1) % NSLOT;
			n_evictions++;
		end
	endfunction

	function automatic stim_row_t make_row(input logic k, input logic signed [VAL_W-1:0] v,
			input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] cut,
			input bit fixed, input logic signed [VAL_W-1:0] want_val, input logic want_has);
		stim_row_t r;
		r.item.kind = k;
		r.item.sample_value = v;
		r.item.sample_time = stamp;
		r.item.cutoff_time = cut;
		r.fixed = fixed;
		r.want.median_value = want_val;
		r.want.has_value = want_has;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick, fill;
		fill = (next_slot + NSLOT - oldest_slot) % NSLOT;
		r.kind = ($urandom_range(99) < 35) ? KIND_QUERY : KIND_ADD;
		pick = $urandom_range(99);
		// mostly a narrow range so that duplicates and ties are common
		if (pick < 55)
			r.sample_value = VAL_W'(int'($urandom_range(12)) - 6);
		else if (pick < 85)
			r.sample_value = VAL_W'($urandom());
		else begin
			case ($urandom_range(3))
				0: r.sample_value = {1'b1, {(VAL_W-1){1'b0}}};
				1: r.sample_value = {1'b0, {(VAL_W-1){1'b1}}};
				2: r.sample_value = '0;
				default: r.sample_value = '1;
			endcase
		end
		if ($urandom_range(99) < 6)
			stamp_now = $urandom();
		else
			stamp_now = stamp_now + TIME_W'($urandom_range(3));
		if (r.kind == KIND_ADD) begin
			r.sample_time = stamp_now;
			r.cutoff_time = $urandom();
		end else begin
			r.sample_time = $urandom();
			pick = $urandom_range(99);
			if (pick < 50 && fill > 0)
				r.cutoff_time = ring_stamp[(oldest_slot + $urandom_range(fill - 1)) % NSLOT];
			else if (pick < 62)
				r.cutoff_time = '0;
			else if (pick < 72)
				r.cutoff_time = '1;
			else if (pick < 82)
				r.cutoff_time = stamp_now + 1;
			else
				r.cutoff_time = $urandom();
		end
		return r;
	endfunction

	task automatic issue_request(input req_t item, input bit fixed, input rsp_t want);
		rsp_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (item.kind == KIND_ADD) begin
			store_sample(item);
			n_adds++;
		end else begin
			got = median_of_window(item.cutoff_time);
			expected_medians.push_back(fixed ? want : got);
			n_queries++;
			if (!got.has_value)
				n_empty++;
		end
	endtask

	// hold off new transactions until every pending query has answered
	task automatic drain_pending();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_medians.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_medians.size() == 0) begin
				$display("%0t unexpected result: expected none actual value %0d has %0b",
					$time, $signed(rsp.median_value), rsp.has_value);
				fail_count++;
			end else begin
				want = expected_medians.pop_front();
				if (rsp.median_value !== want.median_value) begin
					$display("%0t median_value mismatch: expected %0d actual %0d", $time,
						$signed(want.median_value), $signed(rsp.median_value));
					fail_count++;
				end
				if (rsp.has_value !== want.has_value) begin
					$display("%0t has_value mismatch: expected %0b actual %0b", $time,
						want.has_value, rsp.has_value);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(15_000_000);
		$display("timeout with %0d results outstanding", expected_medians.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		int phase;
		// empty ring right after reset
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd0, 1, 24'sd0, 1'b0));
		rows.push_back(make_row(KIND_ADD, 24'sd100, 32'd10, 32'hDEAD_BEEF, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd0, 1, 24'sd100, 1'b1));
		rows.push_back(make_row(KIND_ADD, 24'sh80_0000, 32'd20, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_ADD, 24'sh7F_FFFF, 32'd30, 32'd0, 0, '0, 1'b0));
		// cutoff past the newest time
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd31, 1, 24'sd0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd30, 1, 24'sh7F_FFFF, 1'b1));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd20, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_ADD, 24'shFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0,
			1'b0));
		// unused sample fields all ones on a query
		rows.push_back(make_row(KIND_QUERY, 24'shFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			24'shFF_FFFF, 1'b1));
		rows.push_back(make_row(KIND_ADD, 24'sd0, 32'd5, 32'd0, 0, '0, 1'b0));
		// newest entry is older than cutoff, so the scan stops at once
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd6, 1, 24'sd0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_ADD, 24'sh55_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, '0,
			1'b0));
		rows.push_back(make_row(KIND_ADD, 24'shAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0,
			1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sh55_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, '0,
			1'b0));
		rows.push_back(make_row(KIND_ADD, 24'sd100, 32'h5555_5555, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_ADD, 24'sd100, 32'h5555_5556, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'd0, 0, '0, 1'b0));
		rows.push_back(make_row(KIND_QUERY, 24'sd0, 32'd0, 32'h5555_5555, 0, '0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 88;
		foreach (rows[k])
			issue_request(rows[k].item, rows[k].fixed, rows[k].want);
		drain_pending();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 88 : 0;
			recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 36 : 0;
			repeat (PHASE_ITEMS)
				issue_request(random_request(), 1'b0, '0);
			drain_pending();
		end

		repeat (QUERY_CYCLES) @(posedge clk);
		$display("covered %0d adds and %0d queries, %0d of them on an empty window",
			n_adds, n_queries, n_empty);
		$display("oldest sample dropped from a full ring %0d times", n_evictions);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
